@@ hw/rtl/pod_pkg.sv @@
// pod_pkg: shared types and constants for the pixel outline dilation block.
// Register map codes, window column and result beat structs, fixed limits.
// No dependencies.
package pod_pkg;

	localparam int PIX_W  = 8;
	localparam int SIZE_W = 10;
	localparam int ROW_W  = 10;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// row counters saturate here
	localparam logic [ROW_W-1:0] ROW_LIMIT = 10'd1023;
	// rows beyond this are treated as this many
	localparam int MAX_HEIGHT = 512;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_COLOR  = 2'd2,
		REG_DIAG   = 2'd3
	} reg_idx_t;

	localparam logic [SIZE_W-1:0] RST_WIDTH  = 10'd16;
	localparam logic [SIZE_W-1:0] RST_HEIGHT = 10'd16;
	localparam logic [PIX_W-1:0]  RST_COLOR  = 8'd1;
	localparam logic              RST_DIAG   = 1'b1;

	// one column of the 3x3 neighborhood: only the middle row keeps its value
	typedef struct packed {
		logic             top;
		logic [PIX_W-1:0] mid;
		logic             bot;
	} win_col_t;

	typedef struct packed {
		logic advance;
		logic col_start;
		logic restart;
	} win_ctl_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             last;
	} res_beat_t;

endpackage

@@ hw/rtl/pod_line_store.sv @@
// pod_line_store: single-port-write line buffer with one registered read.
// Write-first on an address collision so the read sees the new word.
// No dependencies.
module pod_line_store #(
	parameter int DEPTH = 512,
	parameter int DW    = 8,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (we && (waddr == raddr)) begin
			rdata_q <= wdata;
		end else begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/pod_window.sv @@
// pod_window: two stored neighborhood columns plus the center judge.
// The incoming column is the right neighbor; the judged center is the newest stored one.
// Depends on pod_pkg.
module pod_window (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pod_pkg::win_ctl_t       ctl,
	input  pod_pkg::win_col_t       new_col,
	input  logic                    diag_en,
	input  logic [pod_pkg::PIX_W-1:0] color,
	output logic [pod_pkg::PIX_W-1:0] result
);
	import pod_pkg::*;

	win_col_t left_q;
	win_col_t cent_q;
	win_col_t right_c;
	logic     hit_orth;
	logic     hit_diag;

	// at a row start the right neighbor lies outside the frame
	assign right_c  = ctl.col_start ? '0 : new_col;
	assign hit_orth = (left_q.mid != '0) || (right_c.mid != '0) || cent_q.top || cent_q.bot;
	assign hit_diag = left_q.top || left_q.bot || right_c.top || right_c.bot;

	always_comb begin
		if (cent_q.mid != '0) begin
			result = cent_q.mid;
		end else if (hit_orth || (diag_en && hit_diag)) begin
			result = color;
		end else begin
			result = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			cent_q <= '0;
		end else if (ctl.restart) begin
			left_q <= '0;
			cent_q <= '0;
		end else if (ctl.advance) begin
			left_q <= ctl.col_start ? '0 : cent_q;
			cent_q <= new_col;
		end
	end

endmodule

@@ hw/rtl/pod_out_buf.sv @@
// pod_out_buf: two-beat result buffer between the pipeline and the result port.
// Full only when two beats wait, so one push and one pop per cycle sustain.
// Depends on pod_pkg.
module pod_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  pod_pkg::res_beat_t  push_beat,
	input  logic                pop,
	output logic                valid,
	output pod_pkg::res_beat_t  beat,
	output logic                full
);
	import pod_pkg::*;

	res_beat_t ent_q [2];
	logic      rd_ptr_q;
	logic      wr_ptr_q;
	logic [1:0] cnt_q;
	logic      pop_ok;

	assign valid  = (cnt_q != 2'd0);
	assign full   = (cnt_q == 2'd2);
	assign beat   = ent_q[rd_ptr_q];
	assign pop_ok = valid && pop;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop_ok) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop_ok);
		end
	end

endmodule

@@ hw/rtl/pixel_outline_dilation.sv @@
// pixel_outline_dilation: streaming 3x3 outline of an 8-bit palette frame.
// Top level: register file, raster counters, line stores, window, result buffer.
// Depends on pod_pkg, pod_line_store, pod_window, pod_out_buf.
//
//  port group | direction | beat contents               | handshake
//  -----------+-----------+-----------------------------+--------------------------------
//  pix        | in        | pixel_value, drain          | pix_valid & pix_ready
//  res        | out       | out_pixel, last             | res_valid & res_ready
//  apb        | in/out    | paddr, pwdata / prdata      | psel & penable & pwrite (pready=1)
//
// One pixel beat per cycle while pix_ready is high. The line stores are read one
// beat ahead at the next column, so a beat's whole step (store read, window shift,
// judge) fits between the state registers and the two-beat result buffer.
// A result is registered into the result buffer by the beat that causes it, width+1
// beats behind its own pixel, and leaves on res from there; width+1 drain beats flush the frame.
// pix_ready drops only while both result buffer entries wait on res_ready.
// Reset clears counters, window and buffer; line stores are not cleared,
// reads of rows that have not been written yet are masked by the row count.
module pixel_outline_dilation #(
	parameter int MAX_WIDTH = 512
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pod_pkg::ADDR_W-1:0]   paddr,
	input  logic [pod_pkg::DATA_W-1:0]   pwdata,
	output logic [pod_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	// pixel beats
	input  logic                         pix_valid,
	output logic                         pix_ready,
	input  logic [pod_pkg::PIX_W-1:0]    pixel_value,
	input  logic                         drain,
	// result beats
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic [pod_pkg::PIX_W-1:0]    out_pixel,
	output logic                         last
);
	import pod_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int SW = (CW + 1 > SIZE_W) ? CW + 1 : SIZE_W;

	// ---------------- configuration registers ----------------
	logic [SIZE_W-1:0] frame_width_q;
	logic [SIZE_W-1:0] frame_height_q;
	logic [PIX_W-1:0]  outline_color_q;
	logic              diagonal_enable_q;
	logic              cfg_wr;
	reg_idx_t          cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q     <= RST_WIDTH;
			frame_height_q    <= RST_HEIGHT;
			outline_color_q   <= RST_COLOR;
			diagonal_enable_q <= RST_DIAG;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_WIDTH:  frame_width_q     <= pwdata[SIZE_W-1:0];
				REG_HEIGHT: frame_height_q    <= pwdata[SIZE_W-1:0];
				REG_COLOR:  outline_color_q   <= pwdata[PIX_W-1:0];
				REG_DIAG:   diagonal_enable_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_WIDTH:  prdata = DATA_W'(frame_width_q);
			REG_HEIGHT: prdata = DATA_W'(frame_height_q);
			REG_COLOR:  prdata = DATA_W'(outline_color_q);
			REG_DIAG:   prdata = DATA_W'(diagonal_enable_q);
			default:    prdata = '0;
		endcase
	end

	// ---------------- effective frame size ----------------
	// zero acts as one, oversize acts as the maximum
	logic [SW-1:0]    fw_ext;
	logic [CW:0]      w;
	logic [ROW_W-1:0] h;

	assign fw_ext = SW'(frame_width_q);

	always_comb begin
		if (fw_ext == '0) begin
			w = (CW + 1)'(1);
		end else if (fw_ext > SW'(MAX_WIDTH)) begin
			w = (CW + 1)'(MAX_WIDTH);
		end else begin
			w = fw_ext[CW:0];
		end
	end

	always_comb begin
		if (frame_height_q == '0) begin
			h = ROW_W'(1);
		end else if (int'(frame_height_q) > MAX_HEIGHT) begin
			h = ROW_W'(MAX_HEIGHT);
		end else begin
			h = frame_height_q;
		end
	end

	// ---------------- raster counters ----------------
	logic [CW-1:0]    in_col_q, in_col_d;
	logic [ROW_W-1:0] in_row_q, in_row_d;
	logic [CW-1:0]    out_col_q, out_col_d;
	logic [ROW_W-1:0] out_row_q, out_row_d;

	logic             buf_full;
	logic             accept;
	logic             active;
	logic             step;
	logic             emit;
	logic             fin;
	logic             last_beat;
	logic [CW:0]      in_col_inc;
	logic [CW:0]      out_col_inc;
	logic [ROW_W:0]   out_row_inc;
	logic             in_wrap;
	logic             out_wrap;
	logic [PIX_W-1:0] px;

	assign pix_ready = !buf_full;
	assign accept    = pix_valid && pix_ready;
	assign active    = (in_row_q < h);
	// drain beats are ignored while frame pixels are still expected
	assign step      = accept && !(active && drain);
	// once the frame is in, every beat is padding
	assign px        = active ? pixel_value : '0;

	assign emit = (in_row_q >= ROW_W'(2)) || ((in_row_q == ROW_W'(1)) && (in_col_q != '0));

	assign in_col_inc  = {1'b0, in_col_q} + (CW + 1)'(1);
	assign out_col_inc = {1'b0, out_col_q} + (CW + 1)'(1);
	assign out_row_inc = {1'b0, out_row_q} + (ROW_W + 1)'(1);
	assign in_wrap     = (in_col_inc >= w);
	assign out_wrap    = (out_col_inc >= w);
	assign last_beat   = (out_row_inc >= {1'b0, h}) && out_wrap;
	assign fin         = step && emit && last_beat;

	always_comb begin
		in_col_d  = in_col_q;
		in_row_d  = in_row_q;
		out_col_d = out_col_q;
		out_row_d = out_row_q;
		if (step) begin
			if (in_wrap) begin
				in_col_d = '0;
				if (in_row_q < ROW_LIMIT) begin
					in_row_d = in_row_q + ROW_W'(1);
				end
			end else begin
				in_col_d = in_col_inc[CW-1:0];
			end
			if (emit) begin
				if (out_wrap) begin
					out_col_d = '0;
					if (out_row_q < ROW_LIMIT) begin
						out_row_d = out_row_q + ROW_W'(1);
					end
				end else begin
					out_col_d = out_col_inc[CW-1:0];
				end
			end
		end
		// frame end: everything back to the origin
		if (fin) begin
			in_col_d  = '0;
			in_row_d  = '0;
			out_col_d = '0;
			out_row_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else begin
			in_col_q  <= in_col_d;
			in_row_q  <= in_row_d;
			out_col_q <= out_col_d;
			out_row_q <= out_row_d;
		end
	end

	// ---------------- line stores ----------------
	// read address is the next beat's column, so data is ready when it arrives
	logic             up_rd;
	logic [PIX_W-1:0] mid_rd;
	logic             top_mark;
	logic [PIX_W-1:0] mid_pix;

	assign top_mark = (in_row_q >= ROW_W'(2)) ? up_rd : 1'b0;
	assign mid_pix  = (in_row_q != '0) ? mid_rd : '0;

	pod_line_store #(
		.DEPTH (MAX_WIDTH),
		.DW    (1)
	) u_upper (
		.clk   (clk),
		.we    (step),
		.waddr (in_col_q),
		.wdata (mid_pix != '0),
		.raddr (in_col_d),
		.rdata (up_rd)
	);

	pod_line_store #(
		.DEPTH (MAX_WIDTH),
		.DW    (PIX_W)
	) u_middle (
		.clk   (clk),
		.we    (step),
		.waddr (in_col_q),
		.wdata (px),
		.raddr (in_col_d),
		.rdata (mid_rd)
	);

	// ---------------- window and judge ----------------
	win_ctl_t         win_ctl;
	win_col_t         win_new;
	logic [PIX_W-1:0] judged;

	assign win_ctl = '{advance: step, col_start: (in_col_q == '0), restart: fin};
	assign win_new = '{top: top_mark, mid: mid_pix, bot: (px != '0)};

	pod_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (win_ctl),
		.new_col (win_new),
		.diag_en (diagonal_enable_q),
		.color   (outline_color_q),
		.result  (judged)
	);

	// ---------------- result buffer ----------------
	res_beat_t push_beat;
	res_beat_t head_beat;

	assign push_beat = '{pixel: judged, last: last_beat};

	pod_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (step && emit),
		.push_beat (push_beat),
		.pop       (res_ready),
		.valid     (res_valid),
		.beat      (head_beat),
		.full      (buf_full)
	);

	assign out_pixel = head_beat.pixel;
	assign last      = head_beat.last;

endmodule

@@ hw/rtl/pod_checker.sv @@
// pod_checker: port-level checks for pixel_outline_dilation, bound to the top.
// Watches result buffering, back-pressure and register readback.
// Depends on pod_pkg.
module pod_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       psel,
	input logic                       penable,
	input logic                       pwrite,
	input logic [pod_pkg::ADDR_W-1:0] paddr,
	input logic [pod_pkg::DATA_W-1:0] pwdata,
	input logic [pod_pkg::DATA_W-1:0] prdata,
	input logic                       pready,
	input logic                       pix_ready,
	input logic                       res_valid,
	input logic                       res_ready,
	input logic [pod_pkg::PIX_W-1:0]  out_pixel,
	input logic                       last
);
	import pod_pkg::*;

	// buffer comes out of reset empty
	a_reset_empty: assert property (@(posedge clk) $rose(arst_n) |-> !res_valid)
		else $error("result beat present right after reset");

	// back-pressure only when results are waiting
	a_stall_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_ready |-> res_valid)
		else $error("pix_ready low with no result waiting");

	// full and not drained stays full
	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready && !pix_ready) |=> !pix_ready)
		else $error("pix_ready rose without a result beat leaving");

	// stalled result beat holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(out_pixel) && $stable(last)))
		else $error("result beat changed while stalled");

	// outline color reads back what was written
	a_color_rb: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready && (paddr[ADDR_W-1:2] == REG_COLOR))
		##1 (paddr[ADDR_W-1:2] == REG_COLOR)
		|-> (prdata[PIX_W-1:0] == $past(pwdata[PIX_W-1:0])))
		else $error("outline color readback mismatch");

endmodule

bind pixel_outline_dilation pod_checker u_pod_checker (.*);
